/* rtl/sic_pkg.sv */
// ----------------------------------------------------------------------------
// sic_pkg: shared definitions for the string interleave checker
// Store sizes, index widths, operation and status codes, and the structs that
// pass between the top level and the evaluation engine.
// ----------------------------------------------------------------------------
package sic_pkg;

  // Store depths.
  localparam int unsigned MAX_FIRST  = 64;
  localparam int unsigned MAX_SECOND = 64;
  localparam int unsigned MAX_TARGET = MAX_FIRST + MAX_SECOND;

  // Symbol width.
  localparam int unsigned SYM_W = 8;

  // Address widths (at least one bit) and count widths (hold the depth itself).
  localparam int unsigned FIRST_AW  = (MAX_FIRST  > 1) ? $clog2(MAX_FIRST)  : 1;
  localparam int unsigned SECOND_AW = (MAX_SECOND > 1) ? $clog2(MAX_SECOND) : 1;
  localparam int unsigned TARGET_AW = (MAX_TARGET > 1) ? $clog2(MAX_TARGET) : 1;
  localparam int unsigned FIRST_CW  = $clog2(MAX_FIRST + 1);
  localparam int unsigned SECOND_CW = $clog2(MAX_SECOND + 1);
  localparam int unsigned TARGET_CW = $clog2(MAX_TARGET + 1);

  // Operation codes carried in tuser.
  localparam logic [2:0] OP_CLEAR       = 3'd0;
  localparam logic [2:0] OP_PUSH_FIRST  = 3'd1;
  localparam logic [2:0] OP_PUSH_SECOND = 3'd2;
  localparam logic [2:0] OP_PUSH_TARGET = 3'd3;
  localparam logic [2:0] OP_EVALUATE    = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Read addresses that the engine drives into the symbol stores.
  typedef struct packed {
    logic [FIRST_AW-1:0]  first_addr;
    logic [SECOND_AW-1:0] second_addr;
    logic [TARGET_AW-1:0] target_addr;
  } sic_rd_req_t;

  // Registered read data returned by the symbol stores.
  typedef struct packed {
    logic [SYM_W-1:0] first_sym;
    logic [SYM_W-1:0] second_sym;
    logic [SYM_W-1:0] target_sym;
  } sic_rd_data_t;

  // Engine status toward the top level.
  typedef struct packed {
    logic busy;
    logic done;
    logic match;
  } sic_eval_sts_t;

endpackage

/* rtl/sic_ram.sv */
// ----------------------------------------------------------------------------
// sic_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module sic_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/sic_eval.sv */
// ----------------------------------------------------------------------------
// sic_eval: interleaving table engine
// Walks the table one cell a cycle, row by row, keeping a single row in a RAM.
// An issue stage drives the store reads; a compute stage combines the read
// data and writes the cell back into the row RAM.
// ----------------------------------------------------------------------------
module sic_eval import sic_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FIRST_CW-1:0]  na_i,
  input  logic [SECOND_CW-1:0] nb_i,
  output sic_rd_req_t          rd_req_o,
  input  sic_rd_data_t         rd_data_i,
  output sic_eval_sts_t        sts_o
);

  // Issue stage.
  logic                 run_q, run_d;
  logic [FIRST_CW-1:0]  i_q, i_d;
  logic [SECOND_CW-1:0] j_q, j_d;
  logic                 cell_last;

  // Compute stage.
  logic                 cv_q;
  logic [FIRST_CW-1:0]  ci_q;
  logic [SECOND_CW-1:0] cj_q;
  logic                 clast_q;

  // Table state: column zero, the first-string symbol of the row, the cell
  // just written to the left.
  logic                 col0_q, col0_d;
  logic [SYM_W-1:0]     ca_q, ca_d;
  logic                 prev_q;
  logic                 cell_val;

  // Row RAM signals (entry j-1 holds column j).
  logic                 row_rdata;
  logic                 row_we;
  logic [SECOND_CW-1:0] j_m1;
  logic [SECOND_CW-1:0] cj_m1;
  logic [FIRST_CW-1:0]  i_m1;
  logic [TARGET_CW-1:0] t_idx;

  // Read addresses for cell (i, j).
  always_comb begin
    i_m1  = i_q - FIRST_CW'(1);
    j_m1  = j_q - SECOND_CW'(1);
    t_idx = TARGET_CW'(i_q) + TARGET_CW'(j_q) - TARGET_CW'(1);
    rd_req_o.first_addr  = i_m1[FIRST_AW-1:0];
    rd_req_o.second_addr = j_m1[SECOND_AW-1:0];
    rd_req_o.target_addr = t_idx[TARGET_AW-1:0];
  end

  // Cell walk: j runs 0..nb inside each row, i runs 0..na.
  always_comb begin
    run_d     = run_q;
    i_d       = i_q;
    j_d       = j_q;
    cell_last = (i_q == na_i) && (j_q == nb_i);
    if (start_i) begin
      run_d = 1'b1;
      i_d   = '0;
      j_d   = '0;
    end else if (run_q) begin
      if (j_q == nb_i) begin
        j_d = '0;
        if (i_q == na_i) begin
          run_d = 1'b0;
        end else begin
          i_d = i_q + FIRST_CW'(1);
        end
      end else begin
        j_d = j_q + SECOND_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      cv_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      clast_q <= 1'b0;
    end else begin
      run_q   <= run_d;
      i_q     <= i_d;
      j_q     <= j_d;
      cv_q    <= run_q;
      clast_q <= run_q && cell_last;
    end
  end

  // Cell coordinates follow the reads into the compute stage.
  always_ff @(posedge clk_i) begin
    ci_q <= i_q;
    cj_q <= j_q;
  end

  // Cell recurrence. Column zero only matches first-string symbols; row zero
  // only matches second-string symbols.
  always_comb begin
    col0_d   = col0_q;
    ca_d     = ca_q;
    cell_val = 1'b0;
    if (cj_q == '0) begin
      if (ci_q == '0) begin
        col0_d = 1'b1;
      end else begin
        col0_d = col0_q && (rd_data_i.first_sym == rd_data_i.target_sym);
        ca_d   = rd_data_i.first_sym;
      end
      cell_val = col0_d;
    end else if (ci_q == '0) begin
      cell_val = prev_q && (rd_data_i.second_sym == rd_data_i.target_sym);
    end else begin
      cell_val = ((ca_q == rd_data_i.target_sym) && row_rdata) ||
                 ((rd_data_i.second_sym == rd_data_i.target_sym) && prev_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cv_q) begin
      col0_q <= col0_d;
      ca_q   <= ca_d;
      prev_q <= cell_val;
    end
  end

  // Row RAM write-back. A column is read again only a full row later, after
  // its write has landed.
  assign row_we = cv_q && (cj_q != '0);
  assign cj_m1  = cj_q - SECOND_CW'(1);

  sic_ram #(
    .DEPTH(MAX_SECOND),
    .WIDTH(1)
  ) u_row (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(cj_m1[SECOND_AW-1:0]),
    .wdata_i(cell_val),
    .raddr_i(j_m1[SECOND_AW-1:0]),
    .rdata_o(row_rdata)
  );

  // Status toward the top level.
  assign sts_o.busy  = run_q || cv_q;
  assign sts_o.done  = cv_q && clast_q;
  assign sts_o.match = cell_val;

endmodule

/* rtl/string_interleave_checker.sv */
// ----------------------------------------------------------------------------
// string_interleave_checker: interleaving string checker
// Collects three byte strings and, on evaluate, reports whether the target is
// an order-keeping interleaving of the first and second strings.
//
//   Channel  Direction  tdata (low bit up)               tuser
//   s_axis   in         symbol[7:0]                      operation[2:0]
//   m_axis   out        interleaved[0], status[2:1], 0s  -
//
// Clear, push and unused operations are accepted back to back. Evaluate runs
// (na+1)*(nb+1) cells through the table engine, one cell a cycle; the result
// then passes the pending register into the output register. An overflow or
// length error skips the engine. s_axis is stalled while an evaluation is in
// flight or a result is pending; the output register lets pushes continue while
// a result waits. Reset clears counts and flags only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module string_interleave_checker import sic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // symbol[7:0]
  input  logic [2:0] s_axis_tuser,   // operation[2:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // interleaved[0], status[2:1], zero[7:3]
);

  // Counts and error flag.
  logic [FIRST_CW-1:0]  first_cnt_q;
  logic [SECOND_CW-1:0] second_cnt_q;
  logic [TARGET_CW-1:0] target_cnt_q;
  logic                 ovf_q;

  // Pending result and output register.
  logic                 pend_q;
  logic                 pend_match_q;
  logic [1:0]           pend_status_q;
  logic                 out_valid_q;
  logic                 out_match_q;
  logic [1:0]           out_status_q;

  logic                 in_xfer;
  logic [2:0]           op;
  logic                 first_we, second_we, target_we;
  logic                 len_bad;
  logic                 start;
  logic                 load_out;

  sic_rd_req_t          rd_req;
  sic_rd_data_t         rd_data;
  sic_eval_sts_t        eval_sts;

  // Input transfer decode.
  assign s_axis_tready = !(eval_sts.busy || pend_q);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign op            = s_axis_tuser;

  assign first_we  = in_xfer && (op == OP_PUSH_FIRST)  && (first_cnt_q  < FIRST_CW'(MAX_FIRST));
  assign second_we = in_xfer && (op == OP_PUSH_SECOND) && (second_cnt_q < SECOND_CW'(MAX_SECOND));
  assign target_we = in_xfer && (op == OP_PUSH_TARGET) && (target_cnt_q < TARGET_CW'(MAX_TARGET));

  assign len_bad = (TARGET_CW'(first_cnt_q) + TARGET_CW'(second_cnt_q)) != target_cnt_q;
  assign start   = in_xfer && (op == OP_EVALUATE) && !ovf_q && !len_bad;

  // Counts and overflow flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      target_cnt_q <= '0;
      ovf_q        <= 1'b0;
    end else if (in_xfer) begin
      case (op)
        OP_CLEAR: begin
          first_cnt_q  <= '0;
          second_cnt_q <= '0;
          target_cnt_q <= '0;
          ovf_q        <= 1'b0;
        end
        OP_PUSH_FIRST: begin
          if (first_we) first_cnt_q <= first_cnt_q + FIRST_CW'(1);
          else          ovf_q       <= 1'b1;
        end
        OP_PUSH_SECOND: begin
          if (second_we) second_cnt_q <= second_cnt_q + SECOND_CW'(1);
          else           ovf_q        <= 1'b1;
        end
        OP_PUSH_TARGET: begin
          if (target_we) target_cnt_q <= target_cnt_q + TARGET_CW'(1);
          else           ovf_q        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Symbol stores: pushes write, the engine reads.
  sic_ram #(
    .DEPTH(MAX_FIRST),
    .WIDTH(SYM_W)
  ) u_first (
    .clk_i  (clk_i),
    .we_i   (first_we),
    .waddr_i(first_cnt_q[FIRST_AW-1:0]),
    .wdata_i(s_axis_tdata),
    .raddr_i(rd_req.first_addr),
    .rdata_o(rd_data.first_sym)
  );

  sic_ram #(
    .DEPTH(MAX_SECOND),
    .WIDTH(SYM_W)
  ) u_second (
    .clk_i  (clk_i),
    .we_i   (second_we),
    .waddr_i(second_cnt_q[SECOND_AW-1:0]),
    .wdata_i(s_axis_tdata),
    .raddr_i(rd_req.second_addr),
    .rdata_o(rd_data.second_sym)
  );

  sic_ram #(
    .DEPTH(MAX_TARGET),
    .WIDTH(SYM_W)
  ) u_target (
    .clk_i  (clk_i),
    .we_i   (target_we),
    .waddr_i(target_cnt_q[TARGET_AW-1:0]),
    .wdata_i(s_axis_tdata),
    .raddr_i(rd_req.target_addr),
    .rdata_o(rd_data.target_sym)
  );

  // Table engine.
  sic_eval u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .na_i     (first_cnt_q),
    .nb_i     (second_cnt_q),
    .rd_req_o (rd_req),
    .rd_data_i(rd_data),
    .sts_o    (eval_sts)
  );

  // Pending result, then the output register once it is free.
  assign load_out = pend_q && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer && (op == OP_EVALUATE) && (ovf_q || len_bad)) begin
        pend_q <= 1'b1;
      end else if (eval_sts.done) begin
        pend_q <= 1'b1;
      end else if (load_out) begin
        pend_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && (op == OP_EVALUATE)) begin
      pend_match_q  <= 1'b0;
      pend_status_q <= ovf_q ? STATUS_OVERFLOW : STATUS_MISMATCH;
    end else if (eval_sts.done) begin
      pend_match_q  <= eval_sts.match;
      pend_status_q <= STATUS_OK;
    end
    if (load_out) begin
      out_match_q  <= pend_match_q;
      out_status_q <= pend_status_q;
    end
  end

  // Result transfer.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_status_q, out_match_q};

endmodule
